>>> rtl/assert_macros.svh
// Assertion macros used by the port checker of the neuron block.
// Depends on nothing; included by the files that hold assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication under an active-low reset.
`define LNA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("neuron block assertion failed");
// Next-cycle implication under an active-low reset.
`define LNA_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("neuron block assertion failed");
`endif

>>> rtl/lna_pkg.sv
// Package of the neuron step block: types, saturation and register indexes.
// Depends on nothing; used by the interfaces and the top level.
package lna_pkg;

    localparam int ASC_COUNT_DEF  = 2;
    localparam int RECEPTORS_DEF  = 2;
    localparam int COEF_DEPTH_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_INDEX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_VALUE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_V_DECAY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAK_DRIVE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_V_THRESHOLD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_V_RESET     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_REFR_TICKS  = 3'd7;

    localparam logic OP_SPIKE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef logic signed [31:0] q16_t;
    typedef logic signed [39:0] acc_t;

    localparam acc_t ACC_MAX = 40'sh00_7FFF_FFFF;
    localparam acc_t ACC_MIN = 40'shFF_8000_0000;

    function automatic q16_t sat32(input acc_t v);
        q16_t r;
        if (v > ACC_MAX)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < ACC_MIN)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = q16_t'(v[31:0]);
        end
        return r;
    endfunction

endpackage

>>> rtl/lna_ifs.sv
// Stream interfaces of the neuron step block: input items and result items.
// Depends on lna_pkg for the Q16.16 type.
interface lna_in_if;
    logic              valid;
    logic              ready;
    logic              op;
    logic              receptor;
    lna_pkg::q16_t     weight;
    lna_pkg::q16_t     current_in;
    modport source (output valid, op, receptor, weight, current_in, input ready);
    modport sink (input valid, op, receptor, weight, current_in, output ready);
endinterface

interface lna_out_if;
    logic              valid;
    logic              ready;
    logic              spiked;
    lna_pkg::q16_t     membrane_out;
    lna_pkg::q16_t     asc_total;
    logic [15:0]       crossing_frac;
    logic              in_refractory;
    modport source (output valid, spiked, membrane_out, asc_total, crossing_frac,
                    in_refractory, input ready);
    modport sink (input valid, spiked, membrane_out, asc_total, crossing_frac,
                  in_refractory, output ready);
endinterface

>>> rtl/lif_neuron_asc_alpha_step_top.sv
// Top level of the leaky integrate-and-fire neuron step with after-spike currents.
// Depends on lna_pkg and the stream interfaces in lna_ifs.sv.
// A tick runs one shared multiply-accumulate unit; each product term passes through the
// address, multiply and accumulate states, and a spike can add a bit-serial division for
// the 16-bit crossing offset. A refractory tick runs only the synaptic terms, and its
// last one also the after-spike current terms. Reset is asynchronous and clears the
// neuron state; the coefficient table is not cleared.
module lif_neuron_asc_alpha_step_top #(
    parameter int ASC_COUNT  = lna_pkg::ASC_COUNT_DEF,
    parameter int RECEPTORS  = lna_pkg::RECEPTORS_DEF,
    parameter int COEF_DEPTH = lna_pkg::COEF_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lna_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [lna_pkg::CFG_DATA_W-1:0] cfg_data,
    lna_in_if.sink                         item,
    lna_out_if.source                      result
);
    import lna_pkg::*;

    localparam int ASW = (ASC_COUNT > 1) ? $clog2(ASC_COUNT) : 1;
    localparam int RW  = (RECEPTORS > 1) ? $clog2(RECEPTORS) : 1;
    localparam int GW  = (ASW > RW) ? ASW : RW;
    localparam int KW  = $clog2(2 * RECEPTORS + 2);
    localparam int AW  = $clog2(COEF_DEPTH);
    localparam int TIW = 7;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ADDR  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_ACC   = 3'd3;
    localparam logic [2:0] ST_DRIVE = 3'd4;
    localparam logic [2:0] ST_CHECK = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    localparam logic [1:0] PH_ASC = 2'd0;
    localparam logic [1:0] PH_V   = 2'd1;
    localparam logic [1:0] PH_REF = 2'd2;
    localparam logic [1:0] PH_SYN = 2'd3;

    localparam logic [1:0] SRC_TAB    = 2'd0;
    localparam logic [1:0] SRC_VDECAY = 2'd1;
    localparam logic [1:0] SRC_GAIN   = 2'd2;

    logic [2:0]        state_reg;
    logic [1:0]        phase_reg;
    logic [GW-1:0]     g_reg;
    logic [KW-1:0]     k_reg;

    logic [3:0]        coef_index_reg;
    q16_t              v_decay_reg;
    q16_t              input_gain_reg;
    q16_t              leak_drive_reg;
    q16_t              v_threshold_reg;
    q16_t              v_reset_reg;
    logic [15:0]       refr_ticks_reg;

    q16_t              membrane_v_reg;
    q16_t              asc_reg [ASC_COUNT];
    q16_t              y1_reg [RECEPTORS];
    q16_t              y2_reg [RECEPTORS];
    q16_t              pw_reg [RECEPTORS];
    q16_t              latched_reg;
    logic [15:0]       refr_cnt_reg;

    q16_t              cur_reg;
    q16_t              v_old_reg;
    q16_t              drive_reg;
    acc_t              asum_reg;
    acc_t              acc_reg;
    q16_t              op_reg;
    logic [1:0]        src_reg;
    logic              raw_reg;
    logic              zero_reg;
    logic signed [63:0] prod_reg;
    q16_t              rd_data_reg;

    logic [32:0]       rem_reg;
    logic [32:0]       den_reg;
    logic [15:0]       quo_reg;
    logic [3:0]        div_cnt_reg;

    logic              spiked_reg;
    logic [15:0]       offset_reg;
    q16_t              asc_total_reg;

    logic              out_valid_reg;
    logic              out_spiked_reg;
    q16_t              out_membrane_reg;
    q16_t              out_asc_reg;
    logic [15:0]       out_offset_reg;
    logic              out_refr_reg;

    q16_t              coef_mem [COEF_DEPTH];

    logic [ASW-1:0]    ga_w;
    logic [RW-1:0]     gr_w;
    logic [KW-1:0]     kj_w;
    logic [RW-1:0]     vr_w;
    q16_t              t_operand;
    logic [1:0]        t_src;
    logic              t_raw;
    logic              t_store;
    logic              t_gend;
    logic              g_last;
    logic [TIW-1:0]    t_idx;
    logic [AW-1:0]     rd_addr;
    logic [TIW-1:0]    ci_ext;

    q16_t              c_sel;
    logic signed [63:0] prod_rnd;
    acc_t              term_w;
    acc_t              acc_sum;
    q16_t              acc_sat;
    logic signed [33:0] num_w;
    logic signed [33:0] den_w;
    logic [33:0]       rem_sh;
    logic              div_bit;
    logic [15:0]       quo_next;
    logic              item_fire;

    assign item.ready = (state_reg == ST_IDLE);
    assign item_fire  = item.valid && item.ready;

    assign result.valid         = out_valid_reg;
    assign result.spiked        = out_spiked_reg;
    assign result.membrane_out  = out_membrane_reg;
    assign result.asc_total     = out_asc_reg;
    assign result.crossing_frac = out_offset_reg;
    assign result.in_refractory = out_refr_reg;

    assign ga_w   = ASW'(g_reg);
    assign gr_w   = RW'(g_reg);
    assign kj_w   = k_reg - KW'(2);
    assign vr_w   = RW'(kj_w >> 1);
    assign ci_ext = {3'b000, coef_index_reg};

    // Term decoder: operand, coefficient source and store points of each step.
    always_comb
    begin
        int tix;
        tix       = 0;
        t_operand = asc_reg[ga_w];
        t_src     = SRC_TAB;
        t_raw     = 1'b0;
        t_store   = 1'b0;
        t_gend    = 1'b0;
        g_last    = 1'b1;
        case (phase_reg)
            PH_ASC:
            begin
                tix     = int'(ga_w);
                t_store = 1'b1;
                t_gend  = 1'b1;
                g_last  = (int'(g_reg) == ASC_COUNT - 1);
            end
            PH_REF:
            begin
                g_last = (int'(g_reg) == ASC_COUNT - 1);
                if (k_reg == KW'(0))
                begin
                    t_raw = 1'b1;
                    tix   = 2 * ASC_COUNT + int'(ga_w);
                end
                else
                begin
                    tix     = ASC_COUNT + int'(ga_w);
                    t_store = 1'b1;
                    t_gend  = 1'b1;
                end
            end
            PH_V:
            begin
                if (k_reg == KW'(0))
                begin
                    t_operand = membrane_v_reg;
                    t_src     = SRC_VDECAY;
                end
                else if (k_reg == KW'(1))
                begin
                    t_operand = drive_reg;
                    t_src     = SRC_GAIN;
                end
                else if (kj_w[0])
                begin
                    t_operand = y2_reg[vr_w];
                    tix       = 3 * ASC_COUNT + 5 * int'(vr_w) + 3;
                end
                else
                begin
                    t_operand = y1_reg[vr_w];
                    tix       = 3 * ASC_COUNT + 5 * int'(vr_w) + 2;
                end
                if (int'(k_reg) == 2 * RECEPTORS + 1)
                begin
                    t_store = 1'b1;
                    t_gend  = 1'b1;
                end
            end
            PH_SYN:
            begin
                g_last = (int'(g_reg) == RECEPTORS - 1);
                case (k_reg)
                    KW'(0):
                    begin
                        t_operand = y1_reg[gr_w];
                        tix       = 3 * ASC_COUNT + 5 * int'(gr_w) + 1;
                    end
                    KW'(1):
                    begin
                        t_operand = y2_reg[gr_w];
                        tix       = 3 * ASC_COUNT + 5 * int'(gr_w);
                        t_store   = 1'b1;
                    end
                    KW'(2):
                    begin
                        t_operand = y1_reg[gr_w];
                        tix       = 3 * ASC_COUNT + 5 * int'(gr_w);
                    end
                    default:
                    begin
                        t_operand = pw_reg[gr_w];
                        tix       = 3 * ASC_COUNT + 5 * int'(gr_w) + 4;
                        t_store   = 1'b1;
                        t_gend    = 1'b1;
                    end
                endcase
            end
            default:
            begin
                tix = 0;
            end
        endcase
        t_idx   = TIW'(tix);
        rd_addr = t_idx[AW-1:0];
    end

    always_comb
    begin
        case (src_reg)
            SRC_VDECAY: c_sel = v_decay_reg;
            SRC_GAIN:   c_sel = input_gain_reg;
            default:    c_sel = zero_reg ? 32'sd0 : rd_data_reg;
        endcase
    end

    assign prod_rnd = prod_reg + 64'sd536870912;
    assign term_w   = acc_t'(prod_rnd >>> 30);
    assign acc_sum  = acc_reg + term_w;
    assign acc_sat  = sat32(acc_sum);

    assign num_w    = 34'(membrane_v_reg) - 34'(v_threshold_reg);
    assign den_w    = 34'(membrane_v_reg) - 34'(v_old_reg);
    assign rem_sh   = {rem_reg, 1'b0};
    assign div_bit  = (rem_sh >= {1'b0, den_reg});
    assign quo_next = {quo_reg[14:0], div_bit};

    always_ff @(posedge clk)
    begin
        if (cfg_we && (cfg_addr == CFG_COEF_VALUE) && (ci_ext < TIW'(COEF_DEPTH)))
        begin
            coef_mem[ci_ext[AW-1:0]] <= q16_t'(cfg_data);
        end
        rd_data_reg <= coef_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= PH_ASC;
            g_reg           <= '0;
            k_reg           <= '0;
            coef_index_reg  <= '0;
            v_decay_reg     <= 32'sd1073741824;
            input_gain_reg  <= '0;
            leak_drive_reg  <= '0;
            v_threshold_reg <= 32'sd1736704;
            v_reset_reg     <= '0;
            refr_ticks_reg  <= 16'd5;
            membrane_v_reg  <= '0;
            latched_reg     <= '0;
            refr_cnt_reg    <= '0;
            for (int a = 0; a < ASC_COUNT; a++)
            begin
                asc_reg[a] <= '0;
            end
            for (int r = 0; r < RECEPTORS; r++)
            begin
                y1_reg[r] <= '0;
                y2_reg[r] <= '0;
                pw_reg[r] <= '0;
            end
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_COEF_INDEX:  coef_index_reg  <= cfg_data[3:0];
                    CFG_V_DECAY:     v_decay_reg     <= q16_t'(cfg_data);
                    CFG_INPUT_GAIN:  input_gain_reg  <= q16_t'(cfg_data);
                    CFG_LEAK_DRIVE:  leak_drive_reg  <= q16_t'(cfg_data);
                    CFG_V_THRESHOLD: v_threshold_reg <= q16_t'(cfg_data);
                    CFG_V_RESET:     v_reset_reg     <= q16_t'(cfg_data);
                    CFG_REFR_TICKS:  refr_ticks_reg  <= cfg_data[15:0];
                    default:         coef_index_reg  <= coef_index_reg;
                endcase
            end

            if (result.valid && result.ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (item_fire)
                    begin
                        if (item.op == OP_SPIKE)
                        begin
                            if (int'(item.receptor) < RECEPTORS)
                            begin
                                pw_reg[RW'(item.receptor)] <=
                                    sat32(acc_t'(pw_reg[RW'(item.receptor)]) +
                                          acc_t'(item.weight));
                            end
                        end
                        else
                        begin
                            cur_reg       <= item.current_in;
                            v_old_reg     <= membrane_v_reg;
                            asum_reg      <= '0;
                            acc_reg       <= '0;
                            g_reg         <= '0;
                            k_reg         <= '0;
                            spiked_reg    <= 1'b0;
                            offset_reg    <= '0;
                            asc_total_reg <= '0;
                            state_reg     <= ST_ADDR;
                            if (refr_cnt_reg != 16'd0)
                            begin
                                refr_cnt_reg <= refr_cnt_reg - 16'd1;
                                if (refr_cnt_reg == 16'd1)
                                begin
                                    membrane_v_reg <= v_reset_reg;
                                    phase_reg      <= PH_REF;
                                end
                                else
                                begin
                                    phase_reg <= PH_SYN;
                                end
                            end
                            else
                            begin
                                phase_reg <= PH_ASC;
                            end
                        end
                    end
                end
                ST_ADDR:
                begin
                    op_reg    <= t_operand;
                    src_reg   <= t_src;
                    raw_reg   <= t_raw;
                    zero_reg  <= (t_idx >= TIW'(COEF_DEPTH));
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    if (raw_reg)
                    begin
                        prod_reg <= 64'(c_sel) <<< 30;
                    end
                    else
                    begin
                        prod_reg <= op_reg * c_sel;
                    end
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (t_store)
                    begin
                        acc_reg <= '0;
                        case (phase_reg)
                            PH_ASC:
                            begin
                                asum_reg      <= asum_reg + acc_t'(asc_reg[ga_w]);
                                asc_reg[ga_w] <= acc_sat;
                            end
                            PH_REF:
                            begin
                                asc_reg[ga_w] <= acc_sat;
                            end
                            PH_V:
                            begin
                                membrane_v_reg <= acc_sat;
                            end
                            default:
                            begin
                                if (k_reg == KW'(1))
                                begin
                                    y2_reg[gr_w] <= acc_sat;
                                end
                                else
                                begin
                                    y1_reg[gr_w] <= acc_sat;
                                    pw_reg[gr_w] <= '0;
                                end
                            end
                        endcase
                    end
                    else
                    begin
                        acc_reg <= acc_sum;
                    end
                    if (t_gend)
                    begin
                        k_reg <= '0;
                        if (g_last)
                        begin
                            g_reg <= '0;
                            case (phase_reg)
                                PH_ASC: state_reg <= ST_DRIVE;
                                PH_V:   state_reg <= ST_CHECK;
                                PH_REF:
                                begin
                                    phase_reg <= PH_SYN;
                                    state_reg <= ST_ADDR;
                                end
                                default: state_reg <= ST_DONE;
                            endcase
                        end
                        else
                        begin
                            g_reg     <= g_reg + GW'(1);
                            state_reg <= ST_ADDR;
                        end
                    end
                    else
                    begin
                        k_reg     <= k_reg + KW'(1);
                        state_reg <= ST_ADDR;
                    end
                end
                ST_DRIVE:
                begin
                    asc_total_reg <= sat32(asum_reg);
                    drive_reg     <= sat32(acc_t'(latched_reg) + acc_t'(sat32(asum_reg)) +
                                           acc_t'(leak_drive_reg));
                    phase_reg     <= PH_V;
                    state_reg     <= ST_ADDR;
                end
                ST_CHECK:
                begin
                    phase_reg <= PH_SYN;
                    if (membrane_v_reg > v_threshold_reg)
                    begin
                        spiked_reg   <= 1'b1;
                        refr_cnt_reg <= refr_ticks_reg;
                        if ((den_w <= 34'sd0) || (num_w >= den_w))
                        begin
                            offset_reg <= 16'hFFFF;
                            state_reg  <= ST_ADDR;
                        end
                        else
                        begin
                            rem_reg     <= num_w[32:0];
                            den_reg     <= den_w[32:0];
                            quo_reg     <= '0;
                            div_cnt_reg <= '0;
                            state_reg   <= ST_DIV;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_ADDR;
                    end
                end
                ST_DIV:
                begin
                    rem_reg     <= div_bit ? 33'(rem_sh - {1'b0, den_reg}) : rem_sh[32:0];
                    quo_reg     <= quo_next;
                    div_cnt_reg <= div_cnt_reg + 4'd1;
                    if (div_cnt_reg == 4'd15)
                    begin
                        offset_reg <= quo_next;
                        state_reg  <= ST_ADDR;
                    end
                end
                default:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_spiked_reg   <= spiked_reg;
                        out_membrane_reg <= membrane_v_reg;
                        out_asc_reg      <= asc_total_reg;
                        out_offset_reg   <= offset_reg;
                        out_refr_reg     <= (refr_cnt_reg != 16'd0);
                        latched_reg      <= cur_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

>>> rtl/lna_checker.sv
// Port-level checker of the neuron step block and its bind to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module lna_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_op,
    input logic        out_valid,
    input logic        out_ready,
    input logic        spiked,
    input logic [31:0] membrane_out,
    input logic [31:0] asc_total,
    input logic [15:0] crossing_frac,
    input logic        in_refractory
);
    // A stalled result transfer keeps its valid, spike flag, membrane value and offset.
    `LNA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(membrane_out) && $stable(crossing_frac) && $stable(spiked))
    // The offset is only reported on a spike.
    `LNA_ASSERT_IMP(a_offset_zero, clk, rst_n, out_valid && !spiked, crossing_frac == 16'd0)
    // A refractory tick without a spike uses no after-spike current.
    `LNA_ASSERT_IMP(a_refr_asc, clk, rst_n, out_valid && in_refractory && !spiked, asc_total == 32'd0)
    // A tick transfer keeps the input closed for the next cycle.
    `LNA_ASSERT_NXT(a_tick_busy, clk, rst_n, in_valid && in_ready && in_op, !in_ready)
endmodule

bind lif_neuron_asc_alpha_step_top lna_port_checker u_lna_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (item.valid),
    .in_ready      (item.ready),
    .in_op         (item.op),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .spiked        (result.spiked),
    .membrane_out  (result.membrane_out),
    .asc_total     (result.asc_total),
    .crossing_frac (result.crossing_frac),
    .in_refractory (result.in_refractory)
);

>>> tb/lna_checker.sv
// Checker of the neuron step block: watches the configuration port and both streams,
// predicts every tick result and compares it with the block's output.
// Depends on lna_pkg and the stream interfaces lna_in_if and lna_out_if.
module lna_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lna_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [lna_pkg::CFG_DATA_W-1:0] cfg_data,
    lna_in_if                              item,
    lna_out_if                             result,
    output int                             fail_count,
    output int                             pending,
    output int                             spike_count,
    output int                             tick_count
);
    import lna_pkg::*;

    localparam int NA = 2;
    localparam int NR = 2;

    typedef struct packed {
        logic        spiked;
        q16_t        membrane;
        q16_t        asc;
        logic [15:0] offset;
        logic        refr;
    } tick_result_t;

    logic [3:0]  coef_sel;
    q16_t        coef_tab [16];
    q16_t        decay_q;
    q16_t        gain_q;
    q16_t        leak_q;
    q16_t        vth_q;
    q16_t        vreset_q;
    logic [15:0] refr_len;

    q16_t        v_mem;
    q16_t        asc_i [NA];
    q16_t        y1 [NR];
    q16_t        y2 [NR];
    q16_t        pend_w [NR];
    q16_t        i_latched;
    logic [15:0] refr_cnt;

    tick_result_t expected_ticks [$];

    function automatic q16_t clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return q16_t'(v);
    endfunction

    function automatic longint qmul(input q16_t a, input q16_t c);
        return (longint'(a) * longint'(c) + (longint'(1) << 29)) >>> 30;
    endfunction

    task automatic advance_tick(input q16_t cur, output tick_result_t r);
        longint acc;
        longint num;
        longint den;
        longint quo;
        q16_t   v_old;
        q16_t   oy1;
        q16_t   oy2;
        int     b;
        v_old = v_mem;
        r = '0;
        if (refr_cnt > 0)
        begin
            refr_cnt = refr_cnt - 16'd1;
            if (refr_cnt == 0)
            begin
                for (int a = 0; a < NA; a++)
                begin
                    asc_i[a] = clamp32(longint'(coef_tab[2*NA+a]) +
                                       qmul(asc_i[a], coef_tab[NA+a]));
                end
                v_mem = vreset_q;
            end
        end
        else
        begin
            acc = 0;
            for (int a = 0; a < NA; a++)
            begin
                acc += asc_i[a];
                asc_i[a] = clamp32(qmul(asc_i[a], coef_tab[a]));
            end
            r.asc = clamp32(acc);
            acc = longint'(i_latched) + longint'(r.asc) + longint'(leak_q);
            acc = qmul(v_old, decay_q) + qmul(clamp32(acc), gain_q);
            for (int k = 0; k < NR; k++)
            begin
                b = 3*NA + 5*k;
                acc += qmul(y1[k], coef_tab[b+2]) + qmul(y2[k], coef_tab[b+3]);
            end
            v_mem = clamp32(acc);
            if (v_mem > vth_q)
            begin
                num = longint'(v_mem) - longint'(vth_q);
                den = longint'(v_mem) - longint'(v_old);
                r.spiked = 1'b1;
                refr_cnt = refr_len;
                if (den <= 0)
                begin
                    r.offset = 16'hFFFF;
                end
                else
                begin
                    quo = (num <<< 16) / den;
                    r.offset = (quo > 65535) ? 16'hFFFF : quo[15:0];
                end
            end
        end
        for (int k = 0; k < NR; k++)
        begin
            b = 3*NA + 5*k;
            oy1 = y1[k];
            oy2 = y2[k];
            y2[k] = clamp32(qmul(oy1, coef_tab[b+1]) + qmul(oy2, coef_tab[b]));
            y1[k] = clamp32(qmul(oy1, coef_tab[b]) + qmul(pend_w[k], coef_tab[b+4]));
            pend_w[k] = 0;
        end
        i_latched = cur;
        r.membrane = v_mem;
        r.refr = (refr_cnt > 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        tick_result_t exp_r;
        tick_result_t got_r;
        if (!rst_n)
        begin
            coef_sel = '0;
            decay_q = 32'sd1073741824;
            gain_q = 0;
            leak_q = 0;
            vth_q = 32'sd1736704;
            vreset_q = 0;
            refr_len = 16'd5;
            v_mem = 0;
            i_latched = 0;
            refr_cnt = '0;
            for (int k = 0; k < NA; k++)
            begin
                asc_i[k] = 0;
            end
            for (int k = 0; k < NR; k++)
            begin
                y1[k] = 0;
                y2[k] = 0;
                pend_w[k] = 0;
            end
            expected_ticks.delete();
            pending <= 0;
            fail_count <= 0;
            spike_count <= 0;
            tick_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_COEF_INDEX:  coef_sel = cfg_data[3:0];
                    CFG_COEF_VALUE:  coef_tab[coef_sel] = cfg_data;
                    CFG_V_DECAY:     decay_q = cfg_data;
                    CFG_INPUT_GAIN:  gain_q = cfg_data;
                    CFG_LEAK_DRIVE:  leak_q = cfg_data;
                    CFG_V_THRESHOLD: vth_q = cfg_data;
                    CFG_V_RESET:     vreset_q = cfg_data;
                    CFG_REFR_TICKS:  refr_len = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
            begin
                if (item.op == OP_SPIKE)
                begin
                    pend_w[item.receptor] = clamp32(longint'(pend_w[item.receptor]) +
                                                    longint'(item.weight));
                end
                else
                begin
                    advance_tick(item.current_in, exp_r);
                    expected_ticks.push_back(exp_r);
                    tick_count <= tick_count + 1;
                end
            end
            if (result.valid && result.ready)
            begin
                got_r = {result.spiked, result.membrane_out, result.asc_total,
                         result.crossing_frac, result.in_refractory};
                if (expected_ticks.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                    begin
                        $display("unexpected result transfer: %p", got_r);
                    end
                end
                else
                begin
                    exp_r = expected_ticks.pop_front();
                    if (got_r.spiked)
                    begin
                        spike_count <= spike_count + 1;
                    end
                    if (got_r.spiked !== exp_r.spiked || got_r.membrane !== exp_r.membrane ||
                        got_r.asc !== exp_r.asc || got_r.offset !== exp_r.offset ||
                        got_r.refr !== exp_r.refr)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                        begin
                            $display("mismatch expected spiked=%0d v=%0d asc=%0d off=%0d refr=%0d",
                                     exp_r.spiked, exp_r.membrane, exp_r.asc, exp_r.offset,
                                     exp_r.refr);
                            $display("         actual   spiked=%0d v=%0d asc=%0d off=%0d refr=%0d",
                                     got_r.spiked, got_r.membrane, got_r.asc, got_r.offset,
                                     got_r.refr);
                        end
                    end
                end
            end
            pending <= expected_ticks.size();
        end
    end

endmodule

>>> tb/tb_lif_neuron_asc_alpha_step_top.sv
// Top of the neuron step testbench: clock, reset, configuration phases and stimulus.
// Depends on lna_pkg, the stream interfaces, the block and lna_checker.
module tb_lif_neuron_asc_alpha_step_top;
    import lna_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_request;
    int  items_sent;
    int  fail_count;
    int  pending;
    int  spike_count;
    int  tick_count;

    lna_in_if  item_if ();
    lna_out_if result_if ();

    lif_neuron_asc_alpha_step_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .item     (item_if),
        .result   (result_if)
    );

    lna_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .item        (item_if),
        .result      (result_if),
        .fail_count  (fail_count),
        .pending     (pending),
        .spike_count (spike_count),
        .tick_count  (tick_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : receiver
        int hold_left;
        bit hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_left = 3000;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready = 1'b0;
            end
            else
            begin
                result_if.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [31:0] data);
        cfg_we = 1'b1;
        cfg_addr = addr;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [31:0] pick_edge(input logic [31:0] lo, input logic [31:0] hi);
        case ($urandom_range(3))
            0: return lo;
            1: return hi;
            2: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic load_setting(input int kind);
        logic [31:0] v;
        for (int i = 0; i < 16; i++)
        begin
            if (kind == 2)
            begin
                v = pick_edge(32'h8000_0000, 32'h7FFF_FFFF);
            end
            else if (i < 2)
            begin
                v = $urandom_range(1063004405, 858993459);
            end
            else if (i < 4)
            begin
                v = $urandom_range(1073741824);
            end
            else if (i < 6)
            begin
                v = $urandom_range(655360) - 327680;
            end
            else
            begin
                case ((i - 6) % 5)
                    0: v = $urandom_range(1063004405, 858993459);
                    1, 2, 3: v = $urandom_range(107374182);
                    default: v = $urandom_range(1073741824);
                endcase
            end
            write_reg(CFG_COEF_INDEX, i);
            write_reg(CFG_COEF_VALUE, v);
        end
        if (kind == 2)
        begin
            write_reg(CFG_V_DECAY, pick_edge(32'h8000_0000, 32'h7FFF_FFFF));
            write_reg(CFG_INPUT_GAIN, pick_edge(32'h8000_0000, 32'h7FFF_FFFF));
            write_reg(CFG_LEAK_DRIVE, pick_edge(32'h8000_0000, 32'h7FFF_FFFF));
            write_reg(CFG_V_THRESHOLD, pick_edge(32'h8000_0000, 32'h7FFF_FFFF));
            write_reg(CFG_V_RESET, pick_edge(32'h8000_0000, 32'h7FFF_FFFF));
            write_reg(CFG_REFR_TICKS, pick_edge(32'd1, 32'd65535) & 32'hFFFF);
        end
        else
        begin
            write_reg(CFG_V_DECAY, $urandom_range(1073741824, 858993459));
            write_reg(CFG_INPUT_GAIN, $urandom_range(322122547));
            write_reg(CFG_LEAK_DRIVE, $urandom_range(655360) - 327680);
            write_reg(CFG_V_THRESHOLD, $urandom_range(1966080, 327680));
            write_reg(CFG_V_RESET, $urandom_range(327680));
            write_reg(CFG_REFR_TICKS, (kind == 1) ? 0 : $urandom_range(8));
        end
    endtask

    task automatic send_item(input logic op, input logic rec, input q16_t w, input q16_t cur);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_if.valid = 1'b0;
            @(negedge clk);
        end
        item_if.valid = 1'b1;
        item_if.op = op;
        item_if.receptor = rec;
        item_if.weight = w;
        item_if.current_in = cur;
        @(posedge clk);
        while (!item_if.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
        @(negedge clk);
    endtask

    function automatic q16_t rand_value();
        case ($urandom_range(9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3, 4: return $urandom;
            default: return $urandom_range(1310720) - 655360;
        endcase
    endfunction

    task automatic drain();
        item_if.valid = 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (100) @(negedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        item_if.valid = 1'b0;
        item_if.op = OP_SPIKE;
        item_if.receptor = 1'b0;
        item_if.weight = '0;
        item_if.current_in = '0;
        send_idle_pct = 7;
        recv_idle_pct = 88;
        hold_request = 1'b0;
        items_sent = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        load_setting(0);
        write_reg(CFG_V_THRESHOLD, 32'h8000_0000);
        send_item(OP_SPIKE, 1'b0, 32'sh7FFF_FFFF, 0);
        send_item(OP_SPIKE, 1'b0, 32'sh7FFF_FFFF, 0);
        send_item(OP_SPIKE, 1'b1, 32'sh8000_0000, 0);
        send_item(OP_SPIKE, 1'b1, 32'sh8000_0000, 0);
        send_item(OP_TICK, 1'b0, 0, 32'sh7FFF_FFFF);
        for (int i = 0; i < 8; i++)
        begin
            send_item(OP_TICK, i[0], 32'sh7FFF_FFFF, (i < 4) ? 32'sh8000_0000 : 0);
        end
        drain();
        write_reg(CFG_V_THRESHOLD, 32'h7FFF_FFFF);
        write_reg(CFG_REFR_TICKS, 0);
        send_item(OP_SPIKE, 1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_item(OP_TICK, 1'b1, 0, 32'sh7FFF_FFFF);
        send_item(OP_TICK, 1'b0, 0, 0);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            send_idle_pct = (phase < 3) ? 7 : (phase < 6) ? 88 : 0;
            recv_idle_pct = (phase < 3) ? 88 : (phase < 6) ? 7 : 0;
            load_setting(phase % 3);
            for (int n = 0; n < 250; n++)
            begin
                if (phase == 1 && n == 20)
                begin
                    hold_request = 1'b1;
                end
                if (phase == 1 && n == 30)
                begin
                    hold_request = 1'b0;
                end
                send_item(($urandom_range(9) < 4) ? OP_SPIKE : OP_TICK, 1'($urandom_range(1)),
                          rand_value(), rand_value());
            end
            drain();
        end

        $display("covered %0d transfers in, %0d ticks predicted, %0d spikes seen",
                 items_sent, tick_count, spike_count);
        $display("across default, refractory-free and saturating settings");
        if (fail_count == 0 && pending == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
